[src/tqc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, status codes and quorum arithmetic for the timeout quorum collector.
// No dependencies; imported by every module of the block but tqc_fifo.
package tqc_pkg;

  localparam int unsigned RID_W   = 7;   // replica id once checked (1..64)
  localparam int unsigned VIEW_W  = 63;  // non-negative view
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned TALLY_W = 7;
  localparam int unsigned QUO_W   = 6;
  localparam int unsigned SET_W   = 64;  // voter bitmap as seen on the result port

  // Reset values of the configuration registers
  localparam logic [RID_W-1:0]  RESET_TOTAL = 7'd4;
  localparam logic [VIEW_W-1:0] RESET_VIEW  = 63'd1;

  // Register indexes
  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_VIEW  = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_BAD_REPLICA = 3'd2,
    ST_BAD_VIEW    = 3'd3,
    ST_WRONG_VIEW  = 3'd4,
    ST_BAD_QC      = 3'd5
  } status_t;

  // Live configuration seen by the classifier and the store
  typedef struct packed {
    logic [RID_W-1:0]  n_live;
    logic [VIEW_W-1:0] goal_view;
    logic [QUO_W-1:0]  quorum;
  } cfg_t;

  // Classified vote handed from the front to the back
  typedef struct packed {
    status_t           status;
    logic [RID_W-1:0]  rid;
    logic [VIEW_W-1:0] qc_view;
    logic [HASH_W-1:0] qc_hash;
  } vote_t;

  // One result beat
  typedef struct packed {
    status_t            status;
    logic [TALLY_W-1:0] votes_held;
    logic               cert_formed;
    logic [VIEW_W-1:0]  qc_view;
    logic [HASH_W-1:0]  qc_hash;
    logic [SET_W-1:0]   voter_set;
  } result_t;

  // Quorum 2*floor((n-1)/3)+1; divide by three as multiply by 43, shift by 7
  function automatic logic [QUO_W-1:0] quorum_of(input logic [RID_W-1:0] n);
    logic [RID_W-1:0] m1;
    logic [12:0]      prod;
    logic [5:0]       third;
    m1    = n - 7'd1;
    prod  = 13'(m1) * 13'd43;
    third = prod[12:7];
    if (n == '0) begin
      quorum_of = '0;
    end else begin
      quorum_of = {third[4:0], 1'b1};
    end
  endfunction

endpackage

[src/timeout_quorum_collector_top.sv]
`timescale 1ns / 1ps
// Timeout quorum collector: one result per vote, one vote per cycle sustained while
// the result queue is not full. The front classifies into a two-entry vote queue, the
// back updates the store and writes a two-entry result queue.
// Votes wait in the vote queue while the result queue is full.
// Reset (synchronous, rst_n low) empties both queues and the store, replica_total 4,
// goal view 1. Any register write clears the store.
module timeout_quorum_collector_top #(
  parameter int unsigned MAX_REPLICAS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // vote channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_voter_id,
  input  logic [63:0] in_vote_view,
  input  logic [63:0] in_top_qc_view,
  input  logic [63:0] in_high_qc_hash,
  input  logic        in_hash_present,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [6:0]  out_votes_held,
  output logic [5:0]  out_quorum_needed,
  output logic        out_cert_formed,
  output logic [62:0] out_cert_qc_view,
  output logic [63:0] out_cert_qc_hash,
  output logic [63:0] out_voter_set,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import tqc_pkg::*;

  logic [RID_W-1:0]  replica_total_r, replica_total_nxt;
  logic [VIEW_W-1:0] goal_view_r, goal_view_nxt;
  logic              cfg_wr;
  logic              reg_sel;
  cfg_t              cfg;
  vote_t             vote_in, vote_head;
  result_t           res_in, res_head;
  logic              vote_empty, vote_take, res_full;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3];

  always_comb begin
    replica_total_nxt = replica_total_r;
    goal_view_nxt     = goal_view_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_TOTAL: replica_total_nxt = pwdata[RID_W-1:0];
        REG_VIEW:  goal_view_nxt     = pwdata[VIEW_W-1:0];
        default:   replica_total_nxt = replica_total_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replica_total_r <= RESET_TOTAL;
      goal_view_r     <= RESET_VIEW;
    end else begin
      replica_total_r <= replica_total_nxt;
      goal_view_r     <= goal_view_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TOTAL: prdata = 64'(replica_total_r);
      REG_VIEW:  prdata = 64'(goal_view_r);
      default:   prdata = '0;
    endcase
  end

  // Clamp the replica count and derive the quorum
  always_comb begin
    cfg.n_live    = (replica_total_r > RID_W'(MAX_REPLICAS)) ? RID_W'(MAX_REPLICAS)
                                                            : replica_total_r;
    cfg.goal_view = goal_view_r;
    cfg.quorum    = quorum_of(cfg.n_live);
  end

  tqc_front u_front (
    .cfg          (cfg),
    .voter_id     (in_voter_id),
    .vote_view    (in_vote_view),
    .top_qc_view  (in_top_qc_view),
    .high_qc_hash (in_high_qc_hash),
    .hash_present (in_hash_present),
    .vote         (vote_in)
  );

  tqc_fifo #(
    .WIDTH ($bits(vote_t)),
    .DEPTH (2)
  ) u_vote_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (vote_in),
    .rd_en   (vote_take),
    .rd_data (vote_head),
    .full    (full),
    .empty   (vote_empty)
  );

  tqc_back #(
    .MAX_REPLICAS (MAX_REPLICAS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_wr),
    .quorum     (cfg.quorum),
    .vote_valid (!vote_empty),
    .vote       (vote_head),
    .res_full   (res_full),
    .vote_take  (vote_take),
    .res        (res_in)
  );

  tqc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (vote_take),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_head),
    .full    (res_full),
    .empty   (empty)
  );

  // Drive the result beat
  assign out_status        = res_head.status;
  assign out_votes_held    = res_head.votes_held;
  assign out_quorum_needed = cfg.quorum;
  assign out_cert_formed   = res_head.cert_formed;
  assign out_cert_qc_view  = res_head.qc_view;
  assign out_cert_qc_hash  = res_head.qc_hash;
  assign out_voter_set     = res_head.voter_set;

  // Tally always matches the bitmap it counts
  a_tally_matches_set: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ($countones(out_voter_set) == 32'(out_votes_held)))
    else $error("vote tally disagrees with voter bitmap");

  // No hash is held while no QC view above zero is chosen
  a_hash_needs_view: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_cert_qc_view == '0)) |-> (out_cert_qc_hash == '0))
    else $error("certificate hash held without a QC view");

  // An accepted vote leaves its replica in the bitmap
  a_accept_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status == ST_ACCEPTED)) |-> (out_voter_set != '0))
    else $error("accepted vote missing from voter bitmap");

endmodule

[src/tqc_fifo.sv]
`timescale 1ns / 1ps
// Small first-in first-out queue with registered occupancy flags.
// Depends on nothing; DEPTH must be a power of two.
module tqc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[src/tqc_front.sv]
`timescale 1ns / 1ps
// Front end: checks replica, view, target match and high QC of each incoming vote.
// Depends on tqc_pkg; feeds the vote queue ahead of tqc_back.
module tqc_front (
  input  tqc_pkg::cfg_t  cfg,
  input  logic [7:0]     voter_id,
  input  logic [63:0]    vote_view,
  input  logic [63:0]    top_qc_view,
  input  logic [63:0]    high_qc_hash,
  input  logic           hash_present,
  output tqc_pkg::vote_t vote
);
  import tqc_pkg::*;

  logic bad_replica, bad_view, off_view, bad_qc;

  // Checks in priority order
  assign bad_replica = (voter_id == '0) || (voter_id > {1'b0, cfg.n_live});
  assign bad_view    = vote_view[63] || (vote_view == '0) || (cfg.goal_view == '0);
  assign off_view    = (vote_view != {1'b0, cfg.goal_view});
  assign bad_qc      = top_qc_view[63] || (top_qc_view > vote_view)
                       || ((top_qc_view != '0) && !hash_present);

  always_comb begin
    if (bad_replica) begin
      vote.status = ST_BAD_REPLICA;
    end else if (bad_view) begin
      vote.status = ST_BAD_VIEW;
    end else if (off_view) begin
      vote.status = ST_WRONG_VIEW;
    end else if (bad_qc) begin
      vote.status = ST_BAD_QC;
    end else begin
      vote.status = ST_ACCEPTED;
    end
    vote.rid     = voter_id[RID_W-1:0];
    vote.qc_view = top_qc_view[VIEW_W-1:0];
    vote.qc_hash = high_qc_hash;
  end

endmodule

[src/tqc_back.sv]
`timescale 1ns / 1ps
// Back end: voter bitmap, tally, best high QC and certificate freeze.
// Depends on tqc_pkg; drains the vote queue into the result queue.
module tqc_back #(
  parameter int unsigned MAX_REPLICAS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic [5:0]       quorum,
  input  logic             vote_valid,
  input  tqc_pkg::vote_t   vote,
  input  logic             res_full,
  output logic             vote_take,
  output tqc_pkg::result_t res
);
  import tqc_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_REPLICAS);

  logic [MAX_REPLICAS-1:0] voter_r, voter_nxt;
  logic [TALLY_W-1:0]      tally_r, tally_nxt;
  logic [VIEW_W-1:0]       best_view_r, best_view_nxt;
  logic [HASH_W-1:0]       best_hash_r, best_hash_nxt;
  logic [RID_W-1:0]        best_rid_r, best_rid_nxt;
  logic                    formed_r, formed_nxt;
  logic [RID_W-1:0]        rid_m1;
  logic [IDX_W-1:0]        idx;
  logic                    dup, take_new, better;

  assign vote_take = vote_valid && !res_full;
  assign rid_m1    = vote.rid - 7'd1;
  assign idx       = rid_m1[IDX_W-1:0];
  assign dup       = voter_r[idx];
  assign take_new  = vote_take && (vote.status == ST_ACCEPTED) && !dup;
  assign better    = (vote.qc_view != '0) && !formed_r
                     && ((vote.qc_view > best_view_r)
                         || ((vote.qc_view == best_view_r) && (vote.rid < best_rid_r)));

  // Update the store for a fresh vote
  always_comb begin
    voter_nxt     = voter_r;
    tally_nxt     = tally_r;
    best_view_nxt = best_view_r;
    best_hash_nxt = best_hash_r;
    best_rid_nxt  = best_rid_r;
    formed_nxt    = formed_r;
    if (take_new) begin
      voter_nxt[idx] = 1'b1;
      tally_nxt      = tally_r + 7'd1;
      if (better) begin
        best_view_nxt = vote.qc_view;
        best_hash_nxt = vote.qc_hash;
        best_rid_nxt  = vote.rid;
      end
      if (tally_nxt >= {1'b0, quorum}) begin
        formed_nxt = 1'b1;
      end
    end
  end

  // Build the result beat from the updated store
  always_comb begin
    if ((vote.status == ST_ACCEPTED) && dup) begin
      res.status = ST_DUPLICATE;
    end else begin
      res.status = vote.status;
    end
    res.votes_held  = tally_nxt;
    res.cert_formed = formed_nxt;
    res.qc_view     = best_view_nxt;
    res.qc_hash     = best_hash_nxt;
    res.voter_set   = SET_W'(voter_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      voter_r     <= '0;
      tally_r     <= '0;
      best_view_r <= '0;
      best_hash_r <= '0;
      best_rid_r  <= '0;
      formed_r    <= 1'b0;
    end else begin
      voter_r     <= voter_nxt;
      tally_r     <= tally_nxt;
      best_view_r <= best_view_nxt;
      best_hash_r <= best_hash_nxt;
      best_rid_r  <= best_rid_nxt;
      formed_r    <= formed_nxt;
    end
  end

endmodule

[tb/tqc_vote_checker.sv]
`timescale 1ns / 1ps
// Vote checker for the timeout quorum collector: watches the vote, result and register
// channels, forecasts each result from its own copy of the store, compares field by field.
// Depends on tqc_pkg for the status codes and register indexes.
module tqc_vote_checker #(
  parameter int unsigned MAX_REPLICAS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_voter_id,
  input  logic [63:0] in_vote_view,
  input  logic [63:0] in_top_qc_view,
  input  logic [63:0] in_high_qc_hash,
  input  logic        in_hash_present,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  out_status,
  input  logic [6:0]  out_votes_held,
  input  logic [5:0]  out_quorum_needed,
  input  logic        out_cert_formed,
  input  logic [62:0] out_cert_qc_view,
  input  logic [63:0] out_cert_qc_hash,
  input  logic [63:0] out_voter_set,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic [63:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import tqc_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [6:0]  held;
    logic [5:0]  quorum;
    logic        formed;
    logic [62:0] qc_view;
    logic [63:0] qc_hash;
    logic [63:0] voters;
  } tally_report_t;

  // Register copies
  logic [6:0]  roster;
  logic [62:0] goal_view;

  // Vote store copy
  logic [63:0] ballots;
  logic [6:0]  tally;
  logic [62:0] lead_view;
  logic [63:0] lead_hash;
  logic [6:0]  lead_rid;
  logic        sealed;

  tally_report_t outcome_q[$];

  initial begin
    fail_count = 0;
    checked    = 0;
    pending    = 0;
  end

  task automatic wipe_store();
    ballots   = '0;
    tally     = '0;
    lead_view = '0;
    lead_hash = '0;
    lead_rid  = '0;
    sealed    = 1'b0;
  endtask

  task automatic flag_field(input string field, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      end
    end
  endtask

  // Classify one vote, update the store copy and return the report it causes
  function automatic tally_report_t ballot_outcome(input logic [7:0] rid,
                                                   input logic [63:0] view,
                                                   input logic [63:0] qcv,
                                                   input logic [63:0] hash,
                                                   input logic present);
    tally_report_t r;
    logic [6:0]    live;
    logic [5:0]    quorum;
    logic [63:0]   seat;
    live   = (roster > 7'(MAX_REPLICAS)) ? 7'(MAX_REPLICAS) : roster;
    quorum = (live == 7'd0) ? 6'd0 : 6'(2 * ((int'(live) - 1) / 3) + 1);
    if (rid == 8'd0 || rid > {1'b0, live}) begin
      r.status = ST_BAD_REPLICA;
    end else if (view[63] || view == 64'd0 || goal_view == 63'd0) begin
      r.status = ST_BAD_VIEW;
    end else if (view != {1'b0, goal_view}) begin
      r.status = ST_WRONG_VIEW;
    end else if (qcv[63] || qcv > view) begin
      r.status = ST_BAD_QC;
    end else if (qcv != 64'd0 && !present) begin
      r.status = ST_BAD_QC;
    end else begin
      seat = 64'd1 << (rid - 8'd1);
      if ((ballots & seat) != 64'd0) begin
        r.status = ST_DUPLICATE;
      end else begin
        r.status = ST_ACCEPTED;
        ballots  = ballots | seat;
        tally    = tally + 7'd1;
        // Take the higher QC view; on a tie the lower replica id wins
        if (!sealed && qcv != 64'd0 &&
            (qcv[62:0] > lead_view || (qcv[62:0] == lead_view && rid[6:0] < lead_rid))) begin
          lead_view = qcv[62:0];
          lead_hash = hash;
          lead_rid  = rid[6:0];
        end
        if (!sealed && tally >= {1'b0, quorum}) begin
          sealed = 1'b1;
        end
      end
    end
    r.held    = tally;
    r.quorum  = quorum;
    r.formed  = sealed;
    r.qc_view = lead_view;
    r.qc_hash = lead_hash;
    r.voters  = ballots;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tally_report_t want;
    if (!rst_n) begin
      roster    = RESET_TOTAL;
      goal_view = RESET_VIEW;
      wipe_store();
      outcome_q.delete();
    end else begin
      // Register access: apply writes, check read data
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == {REG_TOTAL, 3'b000}) begin
            roster = pwdata[6:0];
            wipe_store();
          end else if (paddr == {REG_VIEW, 3'b000}) begin
            goal_view = pwdata[62:0];
            wipe_store();
          end
        end else if (paddr == {REG_TOTAL, 3'b000}) begin
          flag_field("replica_total readback", {57'd0, roster}, prdata);
        end else if (paddr == {REG_VIEW, 3'b000}) begin
          flag_field("goal view readback", {1'b0, goal_view}, prdata);
        end
      end

      // Result beat: compare with the oldest forecast
      if (pop && !empty) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result beat with no vote outstanding, status %0d",
                     $time, out_status);
          end
        end else begin
          want = outcome_q.pop_front();
          checked++;
          flag_field("status", 64'(want.status), 64'(out_status));
          flag_field("votes_held", 64'(want.held), 64'(out_votes_held));
          flag_field("quorum_needed", 64'(want.quorum), 64'(out_quorum_needed));
          flag_field("cert_formed", 64'(want.formed), 64'(out_cert_formed));
          flag_field("cert_qc_view", 64'(want.qc_view), 64'(out_cert_qc_view));
          flag_field("cert_qc_hash", want.qc_hash, out_cert_qc_hash);
          flag_field("voter_set", want.voters, out_voter_set);
        end
      end

      // Vote beat: forecast its result
      if (push && !full) begin
        outcome_q.insert(outcome_q.size(),
                         ballot_outcome(in_voter_id, in_vote_view, in_top_qc_view,
                                        in_high_qc_hash, in_hash_present));
      end
    end
    pending <= outcome_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the timeout quorum collector testbench: clock, reset, vote and register stimulus,
// random result back-pressure and the verdict. Depends on tqc_pkg, the block and tqc_vote_checker.
module testbench;
  import tqc_pkg::*;

  localparam int unsigned MAX_REPLICAS = 64;
  localparam int          VOTE_TARGET  = 2025;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_voter_id;
  logic [63:0] in_vote_view;
  logic [63:0] in_top_qc_view;
  logic [63:0] in_high_qc_hash;
  logic        in_hash_present;
  logic        empty;
  logic        pop;
  logic [2:0]  out_status;
  logic [6:0]  out_votes_held;
  logic [5:0]  out_quorum_needed;
  logic        out_cert_formed;
  logic [62:0] out_cert_qc_view;
  logic [63:0] out_cert_qc_hash;
  logic [63:0] out_voter_set;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int checked;

  int          votes_sent = 0;
  int          reg_writes = 0;
  int          cycles = 0;
  int          cur_total = 4;
  logic [62:0] cur_view = 63'd1;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;

  timeout_quorum_collector_top #(.MAX_REPLICAS(MAX_REPLICAS)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_voter_id      (in_voter_id),
    .in_vote_view     (in_vote_view),
    .in_top_qc_view   (in_top_qc_view),
    .in_high_qc_hash  (in_high_qc_hash),
    .in_hash_present  (in_hash_present),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_votes_held   (out_votes_held),
    .out_quorum_needed(out_quorum_needed),
    .out_cert_formed  (out_cert_formed),
    .out_cert_qc_view (out_cert_qc_view),
    .out_cert_qc_hash (out_cert_qc_hash),
    .out_voter_set    (out_voter_set),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  tqc_vote_checker #(.MAX_REPLICAS(MAX_REPLICAS)) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_voter_id      (in_voter_id),
    .in_vote_view     (in_vote_view),
    .in_top_qc_view   (in_top_qc_view),
    .in_high_qc_hash  (in_high_qc_hash),
    .in_hash_present  (in_hash_present),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_votes_held   (out_votes_held),
    .out_quorum_needed(out_quorum_needed),
    .out_cert_formed  (out_cert_formed),
    .out_cert_qc_view (out_cert_qc_view),
    .out_cert_qc_hash (out_cert_qc_hash),
    .out_voter_set    (out_voter_set),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** timeout_quorum_collector_top: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : result_side
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= rst_n && (calm || $urandom_range(99) >= 16);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int live_total();
    return (cur_total > MAX_REPLICAS) ? MAX_REPLICAS : cur_total;
  endfunction

  // Offer one vote and hold it until accepted; then maybe idle a little
  task automatic push_vote(input logic [7:0] rid, input logic [63:0] view,
                           input logic [63:0] qcv, input logic [63:0] hash,
                           input logic present);
    push            <= 1'b1;
    in_voter_id     <= rid;
    in_vote_view    <= view;
    in_top_qc_view  <= qcv;
    in_high_qc_hash <= hash;
    in_hash_present <= present;
    do @(posedge clk); while (full);
    votes_sent++;
    if (!calm && $urandom_range(99) < 10) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every result has been taken
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic bus_beat(input logic wr, input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register on an idle block, with junk above its width, and read it back
  task automatic program_reg(input logic idx, input logic [62:0] value);
    logic [63:0] junk;
    logic [3:0]  addr;
    junk = rand64();
    addr = {idx, 3'b000};
    settle();
    if (idx == REG_TOTAL) begin
      bus_beat(1'b1, addr, {junk[63:7], value[6:0]});
      cur_total = int'(value[6:0]);
    end else begin
      bus_beat(1'b1, addr, {junk[63], value});
      cur_view = value;
    end
    reg_writes++;
    bus_beat(1'b0, addr, 64'd0);
  endtask

  // Mostly well-formed votes for the current view, some broken, some pure noise
  task automatic random_vote();
    logic [7:0]  rid;
    logic [63:0] view;
    logic [63:0] qcv;
    logic        present;
    int          live;
    int          pick;
    live    = live_total();
    view    = {1'b0, cur_view};
    rid     = (live == 0) ? 8'd1 : 8'($urandom_range(1, live));
    present = 1'b1;
    case ($urandom_range(3))
      0: qcv = 64'd0;
      1: qcv = view;
      2: qcv = (view < 64'd3) ? view : 64'($urandom_range(1, 3));
      default: qcv = rand64() % (view + 64'd1);
    endcase
    if (qcv == 64'd0) present = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick >= 72 && pick < 90) begin
      case ($urandom_range(5))
        0: rid = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(live + 1, 255));
        1: view = {1'b1, 63'(rand64())};
        2: view = 64'd0;
        3: view = view ^ (64'd1 << $urandom_range(62));
        4: qcv = ($urandom_range(1) == 0) ? {1'b1, 63'(rand64())} : view + 64'd1;
        default: begin
          qcv     = (view == 64'd0) ? 64'd1 : (rand64() % view) + 64'd1;
          present = 1'b0;
        end
      endcase
    end else if (pick >= 90) begin
      rid     = 8'($urandom);
      view    = rand64();
      qcv     = rand64();
      present = 1'($urandom_range(1));
    end
    push_vote(rid, view, qcv, rand64(), present);
  endtask

  initial begin : stimulus
    int          round;
    int          live;
    int          votes;
    int          pick;
    logic [62:0] view_pick;
    rst_n           = 1'b0;
    push            = 1'b0;
    in_voter_id     = '0;
    in_vote_view    = '0;
    in_top_qc_view  = '0;
    in_high_qc_hash = '0;
    in_hash_present = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: four replicas, quorum three, view one. Walk every rejection first.
    push_vote(8'd0, 64'd1, 64'd0, 64'd0, 1'b0);
    push_vote(8'hFF, 64'd1, 64'd0, '1, 1'b1);
    push_vote(8'd5, 64'd1, 64'd0, 64'd0, 1'b1);
    push_vote(8'd1, '1, 64'd0, 64'd0, 1'b1);
    push_vote(8'd1, 64'd0, 64'd0, 64'd0, 1'b1);
    push_vote(8'd1, 64'd2, 64'd0, 64'd0, 1'b1);
    push_vote(8'd1, 64'd1, 64'h8000_0000_0000_0000, 64'd0, 1'b1);
    push_vote(8'd1, 64'd1, 64'd2, 64'd0, 1'b1);
    // QC view above zero without a hash
    push_vote(8'd1, 64'd1, 64'd1, 64'hDEAD_BEEF, 1'b0);
    // QC view zero: accepted, supplies no hash
    push_vote(8'd2, 64'd1, 64'd0, '1, 1'b0);
    push_vote(8'd2, 64'd1, 64'd0, 64'd0, 1'b0);
    push_vote(8'd4, 64'd1, 64'd1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // Tie on QC view goes to the lower id; this vote also reaches the quorum
    push_vote(8'd3, 64'd1, 64'd1, 64'h5555_5555_5555_5555, 1'b1);
    // Certificate formed: lower id no longer changes the choice
    push_vote(8'd1, 64'd1, 64'd1, 64'h0123_4567_89AB_CDEF, 1'b1);

    // No replicas at all
    program_reg(REG_TOTAL, 63'd0);
    push_vote(8'd1, 64'd1, 64'd0, 64'd0, 1'b1);
    // Oversized total clamps to the maximum
    program_reg(REG_TOTAL, 63'd127);
    push_vote(8'd64, 64'd1, 64'd1, '1, 1'b1);
    push_vote(8'd65, 64'd1, 64'd1, '1, 1'b1);
    // Zero goal view rejects everything as a bad view
    program_reg(REG_VIEW, 63'd0);
    push_vote(8'd1, 64'd1, 64'd0, 64'd0, 1'b1);
    // Largest goal view
    program_reg(REG_VIEW, '1);
    push_vote(8'd2, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, '1, 1'b1);
    push_vote(8'd3, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE, 64'd0, 1'b1);

    // Random rounds: each starts from a cleared store under a fresh setting
    round = 0;
    while (votes_sent < VOTE_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 8) program_reg(REG_TOTAL, 63'($urandom_range(0, 3)));
      else if (pick < 20) program_reg(REG_TOTAL, 63'd64);
      else if (pick < 28) program_reg(REG_TOTAL, 63'($urandom_range(65, 127)));
      else program_reg(REG_TOTAL, 63'($urandom_range(4, 16)));
      if ($urandom_range(2) == 0) begin
        pick = $urandom_range(99);
        if (pick < 5) view_pick = 63'd0;
        else if (pick < 15) view_pick = '1;
        else if (pick < 35) view_pick = 63'd1;
        else if (pick < 65) view_pick = 63'($urandom_range(2, 1000));
        else view_pick = 63'(rand64());
        program_reg(REG_VIEW, view_pick);
      end
      calm = (round >= 8 && round < 12);
      // Hold off the result side while votes keep coming, so the input backs up
      if (round == 4) hold_req = 1'b1;
      live  = live_total();
      votes = (live == 0) ? 12 : live + live / 2 + $urandom_range(0, 8);
      repeat (votes) random_vote();
      round++;
    end
    calm = 1'b0;

    settle();
    $display("Covered %0d votes in %0d rounds with %0d register writes; %0d results compared.",
             votes_sent, round, reg_writes, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("** timeout_quorum_collector_top: PASSED **");
    end else begin
      $display("** timeout_quorum_collector_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
src/tqc_pkg.sv
src/tqc_fifo.sv
src/tqc_front.sv
src/tqc_back.sv
src/timeout_quorum_collector_top.sv
tb/tqc_vote_checker.sv
tb/testbench.sv
